// ===== design/fzh_pkg.sv =====
package fzh_pkg;

   localparam int KERNEL_GROUP_DEF = 16;
   localparam int OFFSET_BITS_DEF  = 44;

   localparam int FIELD_BITS  = 44;
   localparam int DIM_BITS    = 8;
   localparam int COUNT_BITS  = 12;
   localparam int LANE_BITS   = 6;
   localparam int DEPTH_BITS  = 7;
   localparam int EB_BITS     = 4;
   localparam int CHAN_BITS   = 18;
   localparam int NPAD_BITS   = 13;
   localparam int NPC0_BITS   = 20;
   localparam int MAX_DEPTH   = 64;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 12;

   localparam int SETTLE_CYCLES = 2;
   localparam int SETTLE_BITS   = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = PTR_BITS + 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_HEIGHT     = 3'd0,
      REG_WIDTH      = 3'd1,
      REG_CHANNELS   = 3'd2,
      REG_KERNELS    = 3'd3,
      REG_CUBE_DEPTH = 3'd4,
      REG_ELEM_BYTES = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]   height;
      logic [DIM_BITS-1:0]   width;
      logic [COUNT_BITS-1:0] channels;
      logic [COUNT_BITS-1:0] kernels;
      logic [DEPTH_BITS-1:0] cube_depth;
      logic [EB_BITS-1:0]    elem_bytes;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      height:     8'd1,
      width:      8'd1,
      channels:   12'd1,
      kernels:    12'd1,
      cube_depth: 7'd16,
      elem_bytes: 4'd2
   };

   typedef struct packed {
      logic [DIM_BITS-1:0]   row;
      logic [DIM_BITS-1:0]   col;
      logic [COUNT_BITS-1:0] block;
      logic [LANE_BITS-1:0]  lane;
      logic [COUNT_BITS-1:0] kernel;
      logic [FIELD_BITS-1:0] dst_index;
      logic                  last;
   } elem_type;

   function automatic logic [DEPTH_BITS-1:0] eff_depth(input logic [DEPTH_BITS-1:0] d);
      return (d > DEPTH_BITS'(MAX_DEPTH)) ? DEPTH_BITS'(MAX_DEPTH) : d;
   endfunction

   function automatic logic sizes_ok(input cfg_type c);
      return (c.height != '0) && (c.width != '0) && (c.channels != '0) &&
             (c.kernels != '0) && (c.cube_depth != '0) && (c.elem_bytes != '0);
   endfunction

endpackage

// ===== design/fractal_z_to_hwcn_address_gen.sv =====
// Address generator for a DMA that rewrites a weight tensor from fractal-Z
// into plain HWCN. Write the sizes over csr_*, then send one item with
// req_restart high to get element zero and items with req_restart low to get
// each following element, in h, w, c, n order; rsp_last marks the final one
// and further advance items yield nothing until the next restart. A zero size
// gives an empty transfer. One item is taken every cycle while req_stall is low;
// its offsets reach rsp_* through a four-entry queue and a five-stage
// multiply pipeline. After reset and after every csr write the input stalls
// while the padded kernel stride is rebuilt.
module fractal_z_to_hwcn_address_gen #(
   parameter int KERNEL_GROUP = fzh_pkg::KERNEL_GROUP_DEF,
   parameter int OFFSET_BITS  = fzh_pkg::OFFSET_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fzh_pkg::FIELD_BITS-1:0]      rsp_src_byte_offset,
   output logic [fzh_pkg::FIELD_BITS-1:0]      rsp_dst_byte_offset,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fzh_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fzh_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import fzh_pkg::*;

   cfg_type              cfg;
   logic [NPC0_BITS-1:0] np_c0;
   logic                 cfg_busy;
   logic                 queue_full;
   logic                 push;
   elem_type             push_item;
   logic                 pop;
   logic                 head_valid;
   elem_type             head_item;

   fzh_cfg_regs #(
      .KERNEL_GROUP(KERNEL_GROUP)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready),
      .cfg       (cfg),
      .np_c0     (np_c0),
      .busy      (cfg_busy)
   );

   fzh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cfg_busy    (cfg_busy),
      .csr_pending (csr_valid),
      .queue_full  (queue_full),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .push        (push),
      .push_item   (push_item)
   );

   fzh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   fzh_back #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .np_c0               (np_c0),
      .head_valid          (head_valid),
      .head_item           (head_item),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_src_byte_offset (rsp_src_byte_offset),
      .rsp_dst_byte_offset (rsp_dst_byte_offset),
      .rsp_last            (rsp_last)
   );

endmodule

// ===== design/fzh_cfg_regs.sv =====
module fzh_cfg_regs #(
   parameter int KERNEL_GROUP = fzh_pkg::KERNEL_GROUP_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [fzh_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fzh_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output logic                                csr_ready,
   output fzh_pkg::cfg_type                    cfg,
   output logic [fzh_pkg::NPC0_BITS-1:0]       np_c0,
   output logic                                busy
);
   import fzh_pkg::*;

   localparam int GROUP_LOG   = $clog2(KERNEL_GROUP);
   localparam int RECIP_SHIFT = NPAD_BITS + GROUP_LOG;
   localparam int RECIP_BITS  = NPAD_BITS + 2;
   localparam int PROD_BITS   = NPAD_BITS + RECIP_BITS;
   localparam int QG_BITS     = NPAD_BITS + DEPTH_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP =
      RECIP_BITS'(((2 ** RECIP_SHIFT) + KERNEL_GROUP - 1) / KERNEL_GROUP);

   cfg_type                cfg_ff, cfg_in;
   logic [SETTLE_BITS-1:0] settle_ff, settle_in;
   logic [NPAD_BITS-1:0]   npad_ff, npad_in;
   logic [NPC0_BITS-1:0]   np_c0_ff, np_c0_in;
   logic                   write;
   logic [NPAD_BITS-1:0]   padded;
   logic [PROD_BITS-1:0]   prod;
   logic [NPAD_BITS-1:0]   quot;
   logic [QG_BITS-1:0]     qg;
   logic [QG_BITS-1:0]     qg_next;

   assign csr_ready = 1'b1;
   assign write     = csr_valid & csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (csr_index)
            REG_HEIGHT:     cfg_in.height     = csr_wdata[DIM_BITS-1:0];
            REG_WIDTH:      cfg_in.width      = csr_wdata[DIM_BITS-1:0];
            REG_CHANNELS:   cfg_in.channels   = csr_wdata[COUNT_BITS-1:0];
            REG_KERNELS:    cfg_in.kernels    = csr_wdata[COUNT_BITS-1:0];
            REG_CUBE_DEPTH: cfg_in.cube_depth = csr_wdata[DEPTH_BITS-1:0];
            REG_ELEM_BYTES: cfg_in.elem_bytes = csr_wdata[EB_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      if (write) begin
         settle_in = SETTLE_BITS'(SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - SETTLE_BITS'(1);
      end else begin
         settle_in = settle_ff;
      end
   end

   // kernel count rounded up to the group size, by reciprocal
   assign padded  = NPAD_BITS'(cfg_ff.kernels) + NPAD_BITS'(KERNEL_GROUP - 1);
   assign prod    = PROD_BITS'(padded) * PROD_BITS'(RECIP);
   assign quot    = NPAD_BITS'(prod >> RECIP_SHIFT);
   assign qg      = QG_BITS'(quot) * QG_BITS'(KERNEL_GROUP);
   assign qg_next = qg + QG_BITS'(KERNEL_GROUP);

   always_comb begin
      if (QG_BITS'(padded) >= qg_next) begin
         npad_in = NPAD_BITS'(qg_next);
      end else begin
         npad_in = NPAD_BITS'(qg);
      end
   end

   assign np_c0_in = NPC0_BITS'(npad_ff) * NPC0_BITS'(eff_depth(cfg_ff.cube_depth));

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= CFG_RESET;
         settle_ff <= SETTLE_BITS'(SETTLE_CYCLES);
      end else begin
         cfg_ff    <= cfg_in;
         settle_ff <= settle_in;
      end
      npad_ff  <= npad_in;
      np_c0_ff <= np_c0_in;
   end

   assign cfg   = cfg_ff;
   assign np_c0 = np_c0_ff;
   assign busy  = (settle_ff != '0);

endmodule

// ===== design/fzh_front.sv =====
module fzh_front (
   input  logic              clock,
   input  logic              reset,
   input  fzh_pkg::cfg_type  cfg,
   input  logic              cfg_busy,
   input  logic              csr_pending,
   input  logic              queue_full,
   input  logic              req_valid,
   input  logic              req_restart,
   output logic              req_stall,
   output logic              push,
   output fzh_pkg::elem_type push_item
);
   import fzh_pkg::*;

   logic [DIM_BITS-1:0]   row_ff, row_in;
   logic [DIM_BITS-1:0]   col_ff, col_in;
   logic [COUNT_BITS-1:0] block_ff, block_in;
   logic [LANE_BITS-1:0]  lane_ff, lane_in;
   logic [COUNT_BITS-1:0] kernel_ff, kernel_in;
   logic [CHAN_BITS-1:0]  chan_ff, chan_in;
   logic [FIELD_BITS-1:0] dst_ff, dst_in;
   logic                  running_ff, running_in;

   logic [DEPTH_BITS-1:0] eff;
   logic                  accept;
   logic                  go;
   logic                  ok;
   logic                  last_n;
   logic [DIM_BITS:0]     row_inc, col_inc;
   logic [COUNT_BITS:0]   kern_inc;
   logic [CHAN_BITS:0]    chan_inc;
   logic [LANE_BITS:0]    lane_inc;
   logic [CHAN_BITS:0]    chan_wrap;
   logic [CHAN_BITS-1:0]  chan_refresh;

   assign eff       = eff_depth(cfg.cube_depth);
   assign req_stall = cfg_busy | csr_pending | queue_full;
   assign accept    = req_valid & ~req_stall;
   assign go        = req_restart | running_ff;
   assign ok        = sizes_ok(cfg);

   assign row_inc   = {1'b0, row_ff} + (DIM_BITS+1)'(1);
   assign col_inc   = {1'b0, col_ff} + (DIM_BITS+1)'(1);
   assign kern_inc  = {1'b0, kernel_ff} + (COUNT_BITS+1)'(1);
   assign chan_inc  = {1'b0, chan_ff} + (CHAN_BITS+1)'(1);
   assign lane_inc  = {1'b0, lane_ff} + (LANE_BITS+1)'(1);
   assign chan_wrap = {1'b0, chan_ff} - (CHAN_BITS+1)'(lane_ff) + (CHAN_BITS+1)'(eff);
   assign chan_refresh = CHAN_BITS'(block_ff) * CHAN_BITS'(eff) + CHAN_BITS'(lane_ff);

   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      block_in  = block_ff;
      lane_in   = lane_ff;
      kernel_in = kernel_ff;
      chan_in   = chan_ff;
      dst_in    = dst_ff;
      if (req_restart) begin
         row_in    = '0;
         col_in    = '0;
         block_in  = '0;
         lane_in   = '0;
         kernel_in = '0;
         chan_in   = '0;
         dst_in    = '0;
      end else begin
         dst_in = dst_ff + FIELD_BITS'(1);
         if (kern_inc < {1'b0, cfg.kernels}) begin
            kernel_in = kern_inc[COUNT_BITS-1:0];
         end else begin
            kernel_in = '0;
            if (chan_inc < (CHAN_BITS+1)'(cfg.channels)) begin
               if (lane_inc >= eff) begin
                  lane_in  = '0;
                  block_in = block_ff + COUNT_BITS'(1);
                  chan_in  = chan_wrap[CHAN_BITS-1:0];
               end else begin
                  lane_in  = lane_inc[LANE_BITS-1:0];
                  chan_in  = chan_inc[CHAN_BITS-1:0];
               end
            end else begin
               lane_in  = '0;
               block_in = '0;
               chan_in  = '0;
               if (col_inc < {1'b0, cfg.width}) begin
                  col_in = col_inc[DIM_BITS-1:0];
               end else begin
                  col_in = '0;
                  if (row_inc < {1'b0, cfg.height}) begin
                     row_in = row_inc[DIM_BITS-1:0];
                  end else begin
                     row_in = '0;
                  end
               end
            end
         end
      end
   end

   assign last_n = ({1'b0, row_in} + (DIM_BITS+1)'(1) >= {1'b0, cfg.height}) &&
                   ({1'b0, col_in} + (DIM_BITS+1)'(1) >= {1'b0, cfg.width}) &&
                   ({1'b0, chan_in} + (CHAN_BITS+1)'(1) >= (CHAN_BITS+1)'(cfg.channels)) &&
                   ({1'b0, kernel_in} + (COUNT_BITS+1)'(1) >= {1'b0, cfg.kernels});

   assign running_in = ok & ~last_n;
   assign push       = accept & go & ok;

   always_comb begin
      push_item.row       = row_in;
      push_item.col       = col_in;
      push_item.block     = block_in;
      push_item.lane      = lane_in;
      push_item.kernel    = kernel_in;
      push_item.dst_index = dst_in;
      push_item.last      = last_n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         col_ff     <= '0;
         block_ff   <= '0;
         lane_ff    <= '0;
         kernel_ff  <= '0;
         chan_ff    <= '0;
         dst_ff     <= '0;
         running_ff <= 1'b0;
      end else if (accept && go) begin
         row_ff     <= row_in;
         col_ff     <= col_in;
         block_ff   <= block_in;
         lane_ff    <= lane_in;
         kernel_ff  <= kernel_in;
         chan_ff    <= chan_in;
         dst_ff     <= dst_in;
         running_ff <= running_in;
      end else if (cfg_busy) begin
         // cube depth may have changed
         chan_ff <= chan_refresh;
      end
   end

endmodule

// ===== design/fzh_queue.sv =====
module fzh_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fzh_pkg::elem_type push_item,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output fzh_pkg::elem_type head_item
);
   import fzh_pkg::*;

   elem_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign wr_ptr_in = push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full       = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];

endmodule

// ===== design/fzh_back.sv =====
module fzh_back #(
   parameter int OFFSET_BITS = fzh_pkg::OFFSET_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  fzh_pkg::cfg_type                 cfg,
   input  logic [fzh_pkg::NPC0_BITS-1:0]    np_c0,
   input  logic                             head_valid,
   input  fzh_pkg::elem_type                head_item,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [fzh_pkg::FIELD_BITS-1:0]   rsp_src_byte_offset,
   output logic [fzh_pkg::FIELD_BITS-1:0]   rsp_dst_byte_offset,
   output logic                             rsp_last
);
   import fzh_pkg::*;

   localparam int A_BITS   = 20;
   localparam int K_BITS   = 19;
   localparam int D_BITS   = FIELD_BITS + EB_BITS;
   localparam int B_BITS   = 28;
   localparam int P_BITS   = 48;
   localparam int S_BITS   = P_BITS + EB_BITS;
   localparam int WIDE_BITS = 64;
   localparam logic [WIDE_BITS-1:0] OFF_MASK = (OFFSET_BITS >= WIDE_BITS) ?
      {WIDE_BITS{1'b1}} : ((WIDE_BITS'(1) << OFFSET_BITS) - WIDE_BITS'(1));

   logic                  adv;
   logic [DEPTH_BITS-1:0] eff;

   logic                  v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, out_valid_ff;
   logic [A_BITS-1:0]     a1_ff;
   logic [K_BITS-1:0]     k1_ff, k2_ff, k3_ff;
   logic [D_BITS-1:0]     d1_ff, d2_ff, d3_ff, d4_ff, d5_ff;
   logic [DIM_BITS-1:0]   col1_ff;
   logic                  last1_ff, last2_ff, last3_ff, last4_ff, last5_ff;
   logic [B_BITS-1:0]     b2_ff;
   logic [P_BITS-1:0]     p3_ff;
   logic [P_BITS-1:0]     s4_ff;
   logic [S_BITS-1:0]     src5_ff;
   logic [FIELD_BITS-1:0] src_ff, src_in;
   logic [FIELD_BITS-1:0] dst_ff, dst_in;
   logic                  last_ff;
   logic [WIDE_BITS-1:0]  src_wide, dst_wide;

   assign eff = eff_depth(cfg.cube_depth);
   assign adv = ~out_valid_ff | ~rsp_stall;
   assign pop = adv & head_valid;

   assign src_wide = WIDE_BITS'(src5_ff) & OFF_MASK;
   assign dst_wide = WIDE_BITS'(d5_ff) & OFF_MASK;
   assign src_in   = src_wide[FIELD_BITS-1:0];
   assign dst_in   = dst_wide[FIELD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= head_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         out_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // block row: c1*H + h, lane part: n*C0 + c0
         a1_ff    <= A_BITS'(head_item.block) * A_BITS'(cfg.height) +
                     A_BITS'(head_item.row);
         k1_ff    <= K_BITS'(head_item.kernel) * K_BITS'(eff) + K_BITS'(head_item.lane);
         d1_ff    <= D_BITS'(head_item.dst_index) * D_BITS'(cfg.elem_bytes);
         col1_ff  <= head_item.col;
         last1_ff <= head_item.last;

         b2_ff    <= B_BITS'(a1_ff) * B_BITS'(cfg.width) + B_BITS'(col1_ff);
         k2_ff    <= k1_ff;
         d2_ff    <= d1_ff;
         last2_ff <= last1_ff;

         p3_ff    <= P_BITS'(b2_ff) * P_BITS'(np_c0);
         k3_ff    <= k2_ff;
         d3_ff    <= d2_ff;
         last3_ff <= last2_ff;

         s4_ff    <= p3_ff + P_BITS'(k3_ff);
         d4_ff    <= d3_ff;
         last4_ff <= last3_ff;

         src5_ff  <= S_BITS'(s4_ff) * S_BITS'(cfg.elem_bytes);
         d5_ff    <= d4_ff;
         last5_ff <= last4_ff;

         src_ff   <= src_in;
         dst_ff   <= dst_in;
         last_ff  <= last5_ff;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_src_byte_offset = src_ff;
   assign rsp_dst_byte_offset = dst_ff;
   assign rsp_last            = last_ff;

endmodule

// ===== design/fzh_checker.sv =====
module fzh_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [fzh_pkg::FIELD_BITS-1:0]      rsp_src_byte_offset,
   input logic [fzh_pkg::FIELD_BITS-1:0]      rsp_dst_byte_offset,
   input logic                                rsp_last,
   input logic                                csr_valid,
   input logic                                csr_ready
);

   // nothing comes out of a freshly reset pipeline
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_src_byte_offset) && $stable(rsp_dst_byte_offset) &&
         $stable(rsp_last))
      else $error("stalled result item changed");

   // no item is taken in the cycle of a register write
   a_csr_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> req_stall)
      else $error("item taken during register write");

   // derived strides settle before the next item
   a_csr_settle: assert property (@(posedge clock) disable iff (reset)
      $past(csr_valid && csr_ready) |-> req_stall)
      else $error("item taken before register settle");

endmodule

bind fractal_z_to_hwcn_address_gen fzh_checker u_fzh_checker (.*);
